FILE: hdl/sxl_pkg.sv
`timescale 1ns / 1ps
// sxl_pkg: types, codes and character helpers for the s-expression lexer
// used by sxl_step, sxl_fifo and sexpr_token_lexer; no dependencies
package sxl_pkg;

	localparam int LEN_W            = 12;
	localparam int MAX_TOKEN_LENGTH = 4095;
	localparam int FIFO_DEPTH       = 4;
	localparam int FIFO_PTR_W       = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W       = $clog2(FIFO_DEPTH + 1);
	localparam logic [LEN_W-1:0] MAX_ATOM_RESET = LEN_W'(512);
	localparam logic [LEN_W-1:0] LEN_SAT        = LEN_W'(MAX_TOKEN_LENGTH);

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0a;
	localparam logic [7:0] CH_VT     = 8'h0b;
	localparam logic [7:0] CH_FF     = 8'h0c;
	localparam logic [7:0] CH_CR     = 8'h0d;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_OPEN   = 8'h28;
	localparam logic [7:0] CH_CLOSE  = 8'h29;
	localparam logic [7:0] CH_PLUS   = 8'h2b;
	localparam logic [7:0] CH_MINUS  = 8'h2d;
	localparam logic [7:0] CH_DOT    = 8'h2e;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_SEMI   = 8'h3b;
	localparam logic [7:0] CH_UPPER_E = 8'h45;
	localparam logic [7:0] CH_BSLASH = 8'h5c;
	localparam logic [7:0] CH_LOWER_E = 8'h65;

	localparam logic [3:0] K_OPEN    = 4'd0;
	localparam logic [3:0] K_CLOSE   = 4'd1;
	localparam logic [3:0] K_QUOTE   = 4'd2;
	localparam logic [3:0] K_STRING  = 4'd3;
	localparam logic [3:0] K_INTEGER = 4'd4;
	localparam logic [3:0] K_REAL    = 4'd5;
	localparam logic [3:0] K_SYMBOL  = 4'd6;
	localparam logic [3:0] K_DOT     = 4'd7;
	localparam logic [3:0] K_END     = 4'd8;
	localparam logic [3:0] K_ERROR   = 4'd9;

	localparam logic [1:0] E_NONE      = 2'd0;
	localparam logic [1:0] E_UNTERM    = 2'd1;
	localparam logic [1:0] E_TOO_LONG  = 2'd2;

	typedef enum logic [4:0] {
		MODE_BETWEEN = 5'b00001,
		MODE_COMMENT = 5'b00010,
		MODE_STRING  = 5'b00100,
		MODE_ESCAPE  = 5'b01000,
		MODE_ATOM    = 5'b10000
	} mode_t;

	typedef enum logic [10:0] {
		CL_START   = 11'b00000000001,
		CL_SIGN    = 11'b00000000010,
		CL_INT     = 11'b00000000100,
		CL_DOT     = 11'b00000001000,
		CL_SIGNDOT = 11'b00000010000,
		CL_FRAC    = 11'b00000100000,
		CL_INTDOT  = 11'b00001000000,
		CL_EXPMARK = 11'b00010000000,
		CL_EXPSIGN = 11'b00100000000,
		CL_EXPDIG  = 11'b01000000000,
		CL_SYMBOL  = 11'b10000000000
	} class_t;

	typedef struct packed {
		logic [3:0]       kind;
		logic [LEN_W-1:0] length;
		logic [1:0]       err;
		logic             last;
	} token_t;

	typedef struct packed {
		logic             r0_v;
		token_t           r0;
		logic             r1_v;
		token_t           r1;
		mode_t            mode;
		class_t           cls;
		logic [LEN_W-1:0] len;
	} step_t;

	function automatic logic is_space(input logic [7:0] c);
		return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR ||
			c == CH_VT || c == CH_FF;
	endfunction

	function automatic logic is_term(input logic [7:0] c);
		return is_space(c) || c == CH_OPEN || c == CH_CLOSE || c == CH_SQUOTE ||
			c == CH_SEMI || c == CH_DQUOTE;
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	function automatic logic is_sign(input logic [7:0] c);
		return c == CH_PLUS || c == CH_MINUS;
	endfunction

	function automatic logic is_exp(input logic [7:0] c);
		return c == CH_LOWER_E || c == CH_UPPER_E;
	endfunction

	function automatic class_t next_class(input class_t s, input logic [7:0] c);
		class_t r;
		r = CL_SYMBOL;
		case (s)
			CL_START: begin
				if (is_sign(c)) r = CL_SIGN;
				else if (is_digit(c)) r = CL_INT;
				else if (c == CH_DOT) r = CL_DOT;
			end
			CL_SIGN: begin
				if (is_digit(c)) r = CL_INT;
				else if (c == CH_DOT) r = CL_SIGNDOT;
			end
			CL_INT: begin
				if (is_digit(c)) r = CL_INT;
				else if (c == CH_DOT) r = CL_INTDOT;
				else if (is_exp(c)) r = CL_EXPMARK;
			end
			CL_DOT, CL_SIGNDOT, CL_FRAC: begin
				if (is_digit(c)) r = CL_FRAC;
				else if (is_exp(c)) r = CL_EXPMARK;
			end
			CL_INTDOT: begin
				if (is_digit(c)) r = CL_INTDOT;
				else if (is_exp(c)) r = CL_EXPMARK;
			end
			CL_EXPMARK: begin
				if (is_sign(c)) r = CL_EXPSIGN;
				else if (is_digit(c)) r = CL_EXPDIG;
			end
			CL_EXPSIGN, CL_EXPDIG: begin
				if (is_digit(c)) r = CL_EXPDIG;
			end
			default: r = CL_SYMBOL;
		endcase
		return r;
	endfunction

endpackage

FILE: hdl/sexpr_token_lexer.sv
`timescale 1ns / 1ps
// sexpr_token_lexer: top level of the streaming s-expression lexer
// depends on sxl_pkg, sxl_step, sxl_fifo

// Takes one source byte per cycle while the queue has room and returns open,
// close, quote, string, integer, real, symbol, dot, end and error tokens. A
// byte is registered on request, stepped through the lexer state once no more
// than two tokens wait in the four-entry queue, and its tokens (none, one or
// two) go into that queue, which drives the output; the first token is shown
// once its byte has passed the input register and the queue. Input throughput
// is one byte per cycle, set by the state update, under that bound; output
// drains one token per cycle while out_ready is high. The atom length limit
// must be written by the user through the cfg port while idle (not enforced).
module sexpr_token_lexer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [7:0]                    source_byte,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [3:0]                    token_kind,
	output logic [sxl_pkg::LEN_W-1:0]     token_length,
	output logic [1:0]                    fault_code,
	output logic                          last_of_run,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [sxl_pkg::LEN_W-1:0]     cfg_data
);
	import sxl_pkg::*;

	logic [7:0]            byte_s1;
	logic                  valid_s1;
	mode_t                 mode_q;
	class_t                cls_q;
	logic [LEN_W-1:0]      len_q;
	logic [LEN_W-1:0]      max_len_q;
	step_t                 step;
	logic                  advance;
	logic                  pop;
	token_t                head;
	logic [FIFO_CNT_W-1:0] count;

	sxl_step u_step (
		.mode    (mode_q),
		.cls     (cls_q),
		.len     (len_q),
		.c       (byte_s1),
		.max_len (max_len_q),
		.res     (step)
	);

	sxl_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push0  (advance && step.r0_v),
		.data0  (step.r0),
		.push1  (advance && step.r1_v),
		.data1  (step.r1),
		.pop    (pop),
		.head   (head),
		.count  (count)
	);

	assign advance      = valid_s1 && count <= FIFO_CNT_W'(FIFO_DEPTH - 2);
	assign in_ready     = !valid_s1 || advance;
	assign cfg_ready    = 1'b1;
	assign out_valid    = count != '0;
	assign pop          = out_valid && out_ready;
	assign token_kind   = head.kind;
	assign token_length = head.length;
	assign fault_code   = head.err;
	assign last_of_run  = head.last;

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) byte_s1 <= source_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			mode_q    <= MODE_BETWEEN;
			cls_q     <= CL_START;
			len_q     <= '0;
			max_len_q <= MAX_ATOM_RESET;
		end else begin
			if (in_ready) valid_s1 <= in_valid;
			if (advance) begin
				mode_q <= step.mode;
				cls_q  <= step.cls;
				len_q  <= step.len;
			end
			if (cfg_valid && cfg_ready) max_len_q <= cfg_data;
		end
	end

	a_fifo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count <= FIFO_CNT_W'(FIFO_DEPTH))
		else $error("token queue overflow");

	a_end_resets: assert property (@(posedge clk) disable iff (!arst_n)
		advance && step.r0_v && step.r0.kind == K_END |=> mode_q == MODE_BETWEEN)
		else $error("end token left lexer mid-token");

	a_error_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((token_kind == K_ERROR) == (fault_code != E_NONE)))
		else $error("error code does not match token kind");

	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		advance && step.r1_v |-> !step.r0.last && step.r1.last)
		else $error("last flag misplaced on two-token byte");

endmodule

FILE: hdl/sxl_step.sv
`timescale 1ns / 1ps
// sxl_step: next-state and token logic for one source byte
// depends on sxl_pkg
module sxl_step (
	input  sxl_pkg::mode_t              mode,
	input  sxl_pkg::class_t             cls,
	input  logic [sxl_pkg::LEN_W-1:0]   len,
	input  logic [7:0]                  c,
	input  logic [sxl_pkg::LEN_W-1:0]   max_len,
	output sxl_pkg::step_t              res
);
	import sxl_pkg::*;

	logic             pre_v;
	token_t           pre;
	logic             bt_v;
	token_t           bt;
	mode_t            bt_mode;
	class_t           bt_cls;
	logic [LEN_W-1:0] bt_len;
	logic [LEN_W-1:0] len_inc;
	token_t           atom;

	always_comb begin
		len_inc = (len < LEN_SAT) ? len + LEN_W'(1) : len;

		// handling of a byte between tokens
		bt_v    = 1'b0;
		bt      = '{kind: K_END, length: '0, err: E_NONE, last: 1'b0};
		bt_mode = MODE_BETWEEN;
		bt_cls  = CL_START;
		bt_len  = '0;
		if (c == CH_NUL) begin
			bt_v = 1'b1;
		end else if (is_space(c)) begin
			bt_v = 1'b0;
		end else if (c == CH_SEMI) begin
			bt_mode = MODE_COMMENT;
		end else if (c == CH_OPEN) begin
			bt_v = 1'b1;
			bt.kind = K_OPEN;
		end else if (c == CH_CLOSE) begin
			bt_v = 1'b1;
			bt.kind = K_CLOSE;
		end else if (c == CH_SQUOTE) begin
			bt_v = 1'b1;
			bt.kind = K_QUOTE;
		end else if (c == CH_DQUOTE) begin
			bt_mode = MODE_STRING;
		end else begin
			bt_mode = MODE_ATOM;
			bt_len  = LEN_W'(1);
			bt_cls  = next_class(CL_START, c);
		end

		// token for the atom that ends here
		atom = '{kind: K_SYMBOL, length: len, err: E_NONE, last: 1'b0};
		if (len >= max_len) begin
			atom.kind = K_ERROR;
			atom.err  = E_TOO_LONG;
		end else if (cls == CL_INT) begin
			atom.kind = K_INTEGER;
		end else if (cls == CL_FRAC || cls == CL_INTDOT || cls == CL_EXPDIG) begin
			atom.kind = K_REAL;
		end else if (cls == CL_DOT) begin
			atom.kind = K_DOT;
		end

		pre_v    = 1'b0;
		pre      = '{kind: K_ERROR, length: len, err: E_UNTERM, last: 1'b0};
		res      = '0;
		res.mode = mode;
		res.cls  = cls;
		res.len  = len;

		case (mode)
			MODE_COMMENT: begin
				if (c == CH_NUL) begin
					res.mode = bt_mode;
					res.r0_v = bt_v;
					res.r0   = bt;
				end else if (c == CH_LF) begin
					res.mode = MODE_BETWEEN;
				end
			end
			MODE_STRING, MODE_ESCAPE: begin
				if (c == CH_NUL) begin
					pre_v    = 1'b1;
					res.mode = bt_mode;
					res.len  = bt_len;
					res.cls  = bt_cls;
				end else if (mode == MODE_STRING && c == CH_DQUOTE) begin
					pre_v    = 1'b1;
					pre.kind = K_STRING;
					pre.err  = E_NONE;
					res.mode = MODE_BETWEEN;
					res.len  = '0;
				end else begin
					res.len  = len_inc;
					res.mode = (mode == MODE_STRING && c == CH_BSLASH) ?
						MODE_ESCAPE : MODE_STRING;
				end
				res.r0_v = pre_v;
				res.r0   = pre;
				res.r1_v = pre_v && c == CH_NUL;
				res.r1   = bt;
			end
			MODE_ATOM: begin
				if (c == CH_NUL || is_term(c)) begin
					res.r0_v = 1'b1;
					res.r0   = atom;
					res.r1_v = bt_v;
					res.r1   = bt;
					res.mode = bt_mode;
					res.cls  = bt_cls;
					res.len  = bt_len;
				end else begin
					res.len = len_inc;
					res.cls = next_class(cls, c);
				end
			end
			default: begin
				res.r0_v = bt_v;
				res.r0   = bt;
				res.mode = bt_mode;
				res.cls  = bt_cls;
				res.len  = bt_len;
			end
		endcase

		if (res.r1_v) res.r1.last = 1'b1;
		else res.r0.last = 1'b1;
	end

endmodule

FILE: hdl/sxl_fifo.sv
`timescale 1ns / 1ps
// sxl_fifo: small token queue, up to two writes and one read per cycle
// depends on sxl_pkg
module sxl_fifo (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push0,
	input  sxl_pkg::token_t                   data0,
	input  logic                              push1,
	input  sxl_pkg::token_t                   data1,
	input  logic                              pop,
	output sxl_pkg::token_t                   head,
	output logic [sxl_pkg::FIFO_CNT_W-1:0]    count
);
	import sxl_pkg::*;

	token_t                mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_q;
	logic [FIFO_PTR_W-1:0] rd_q;
	logic [FIFO_CNT_W-1:0] cnt_q;
	logic [FIFO_PTR_W-1:0] wr_nx;
	logic [FIFO_CNT_W-1:0] n_push;

	function automatic logic [FIFO_PTR_W-1:0] inc(input logic [FIFO_PTR_W-1:0] p);
		return (p == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + FIFO_PTR_W'(1);
	endfunction

	assign wr_nx  = inc(wr_q);
	assign n_push = FIFO_CNT_W'(push0) + FIFO_CNT_W'(push1);
	assign head   = mem_q[rd_q];
	assign count  = cnt_q;

	always_ff @(posedge clk) begin
		if (push0) mem_q[wr_q] <= data0;
		if (push1) mem_q[wr_nx] <= data1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push0 && push1) wr_q <= inc(wr_nx);
			else if (push0) wr_q <= wr_nx;
			if (pop) rd_q <= inc(rd_q);
			cnt_q <= cnt_q + n_push - FIFO_CNT_W'(pop);
		end
	end

endmodule

FILE: tb/sv/sxl_token_checker.sv
`timescale 1ns / 1ps
// sxl_token_checker: watches the source, token and cfg channels of the lexer,
// predicts the token stream byte by byte and compares every token it sees
// depends on sxl_pkg for the token record, codes and character constants
module sxl_token_checker (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic                      in_ready,
	input  logic [7:0]                source_byte,
	input  logic                      out_valid,
	input  logic                      out_ready,
	input  logic [3:0]                token_kind,
	input  logic [sxl_pkg::LEN_W-1:0] token_length,
	input  logic [1:0]                fault_code,
	input  logic                      last_of_run,
	input  logic                      cfg_valid,
	input  logic                      cfg_ready,
	input  logic [sxl_pkg::LEN_W-1:0] cfg_data,
	output int                        fail_count,
	output int                        backlog,
	output int                        tokens_checked
);
	import sxl_pkg::*;

	mode_t            lex_mode;
	class_t           num_cls;
	logic [LEN_W-1:0] run_len;
	logic [LEN_W-1:0] atom_limit;
	token_t           pending_tokens[$];

	function automatic logic blank_byte(input logic [7:0] c);
		return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR ||
			c == CH_VT || c == CH_FF;
	endfunction

	function automatic logic atom_stop(input logic [7:0] c);
		return c == CH_NUL || blank_byte(c) || c == CH_OPEN || c == CH_CLOSE ||
			c == CH_SQUOTE || c == CH_SEMI || c == CH_DQUOTE;
	endfunction

	function automatic class_t advance_class(input class_t s, input logic [7:0] c);
		logic dig;
		logic sgn;
		logic mark;
		dig  = c >= CH_ZERO && c <= CH_NINE;
		sgn  = c == CH_PLUS || c == CH_MINUS;
		mark = c == CH_LOWER_E || c == CH_UPPER_E;
		case (s)
			CL_START: begin
				if (sgn) return CL_SIGN;
				if (dig) return CL_INT;
				if (c == CH_DOT) return CL_DOT;
			end
			CL_SIGN: begin
				if (dig) return CL_INT;
				if (c == CH_DOT) return CL_SIGNDOT;
			end
			CL_INT: begin
				if (dig) return CL_INT;
				if (c == CH_DOT) return CL_INTDOT;
				if (mark) return CL_EXPMARK;
			end
			CL_DOT, CL_SIGNDOT, CL_FRAC: begin
				if (dig) return CL_FRAC;
				if (mark) return CL_EXPMARK;
			end
			CL_INTDOT: begin
				if (dig) return CL_INTDOT;
				if (mark) return CL_EXPMARK;
			end
			CL_EXPMARK: begin
				if (sgn) return CL_EXPSIGN;
				if (dig) return CL_EXPDIG;
			end
			CL_EXPSIGN, CL_EXPDIG: begin
				if (dig) return CL_EXPDIG;
			end
			default: ;
		endcase
		return CL_SYMBOL;
	endfunction

	task automatic add_token(input logic [3:0] kind, input logic [LEN_W-1:0] len,
		input logic [1:0] err);
		token_t t;
		t.kind   = kind;
		t.length = len;
		t.err    = err;
		t.last   = 1'b0;
		pending_tokens.push_back(t);
	endtask

	task automatic bump_len();
		if (run_len != LEN_SAT)
			run_len = run_len + LEN_W'(1);
	endtask

	task automatic close_atom();
		logic [3:0] kind;
		if (run_len >= atom_limit) begin
			add_token(K_ERROR, run_len, E_TOO_LONG);
		end else begin
			case (num_cls)
				CL_INT: kind = K_INTEGER;
				CL_FRAC, CL_INTDOT, CL_EXPDIG: kind = K_REAL;
				CL_DOT: kind = K_DOT;
				default: kind = K_SYMBOL;
			endcase
			add_token(kind, run_len, E_NONE);
		end
		lex_mode = MODE_BETWEEN;
		num_cls  = CL_START;
		run_len  = '0;
	endtask

	task automatic lex_between(input logic [7:0] c);
		lex_mode = MODE_BETWEEN;
		if (c == CH_NUL) add_token(K_END, '0, E_NONE);
		else if (blank_byte(c)) ;
		else if (c == CH_SEMI) lex_mode = MODE_COMMENT;
		else if (c == CH_OPEN) add_token(K_OPEN, '0, E_NONE);
		else if (c == CH_CLOSE) add_token(K_CLOSE, '0, E_NONE);
		else if (c == CH_SQUOTE) add_token(K_QUOTE, '0, E_NONE);
		else if (c == CH_DQUOTE) begin
			lex_mode = MODE_STRING;
			run_len  = '0;
		end else begin
			lex_mode = MODE_ATOM;
			run_len  = LEN_W'(1);
			num_cls  = advance_class(CL_START, c);
		end
	endtask

	task automatic lex_byte(input logic [7:0] c);
		int     base;
		token_t t;
		base = pending_tokens.size();
		case (lex_mode)
			MODE_COMMENT: begin
				if (c == CH_NUL) lex_between(c);
				else if (c == CH_LF) lex_mode = MODE_BETWEEN;
			end
			MODE_STRING: begin
				if (c == CH_NUL) begin
					add_token(K_ERROR, run_len, E_UNTERM);
					run_len = '0;
					lex_between(c);
				end else if (c == CH_DQUOTE) begin
					add_token(K_STRING, run_len, E_NONE);
					run_len  = '0;
					lex_mode = MODE_BETWEEN;
				end else begin
					bump_len();
					if (c == CH_BSLASH) lex_mode = MODE_ESCAPE;
				end
			end
			MODE_ESCAPE: begin
				if (c == CH_NUL) begin
					add_token(K_ERROR, run_len, E_UNTERM);
					run_len = '0;
					lex_between(c);
				end else begin
					bump_len();
					lex_mode = MODE_STRING;
				end
			end
			MODE_ATOM: begin
				if (atom_stop(c)) begin
					close_atom();
					lex_between(c);
				end else begin
					bump_len();
					num_cls = advance_class(num_cls, c);
				end
			end
			default: lex_between(c);
		endcase
		if (pending_tokens.size() > base) begin
			t = pending_tokens.pop_back();
			t.last = 1'b1;
			pending_tokens.push_back(t);
		end
	endtask

	task automatic compare_field(input string name, input logic [LEN_W-1:0] want,
		input logic [LEN_W-1:0] got);
		if (got !== want) begin
			fail_count++;
			$error("%s: expected %0d, got %0d", name, want, got);
		end
	endtask

	task automatic check_token();
		token_t want;
		tokens_checked++;
		if (pending_tokens.size() == 0) begin
			fail_count++;
			$error("token_kind: expected no token, got %0d", token_kind);
		end else begin
			want = pending_tokens.pop_front();
			compare_field("token_kind", LEN_W'(want.kind), LEN_W'(token_kind));
			compare_field("token_length", want.length, token_length);
			compare_field("fault_code", LEN_W'(want.err), LEN_W'(fault_code));
			compare_field("last_of_run", LEN_W'(want.last), LEN_W'(last_of_run));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lex_mode       = MODE_BETWEEN;
			num_cls        = CL_START;
			run_len        = '0;
			atom_limit     = MAX_ATOM_RESET;
			pending_tokens.delete();
			fail_count     = 0;
			tokens_checked = 0;
			backlog        = 0;
		end else begin
			if (out_valid && out_ready)
				check_token();
			if (cfg_valid && cfg_ready)
				atom_limit = cfg_data;
			if (in_valid && in_ready)
				lex_byte(source_byte);
			backlog = pending_tokens.size();
		end
	end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// tb_top: drives source bytes and atom length limits into sexpr_token_lexer
// with random idling and back pressure; sxl_token_checker predicts and compares
// depends on sxl_pkg, sexpr_token_lexer and sxl_token_checker
module tb_top;
	import sxl_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int LONG_HOLD      = 120;

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_ready;
	logic [7:0]       source_byte;
	logic             out_valid;
	logic             out_ready;
	logic [3:0]       token_kind;
	logic [LEN_W-1:0] token_length;
	logic [1:0]       fault_code;
	logic             last_of_run;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [LEN_W-1:0] cfg_data;

	int               fail_count;
	int               backlog;
	int               tokens_checked;
	int               bytes_sent;
	int               idle_pct;
	bit               long_hold;
	logic [LEN_W-1:0] atom_limit;

	sexpr_token_lexer u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.source_byte  (source_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.token_kind   (token_kind),
		.token_length (token_length),
		.fault_code   (fault_code),
		.last_of_run  (last_of_run),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	sxl_token_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.source_byte    (source_byte),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.token_kind     (token_kind),
		.token_length   (token_length),
		.fault_code     (fault_code),
		.last_of_run    (last_of_run),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.fail_count     (fail_count),
		.backlog        (backlog),
		.tokens_checked (tokens_checked)
	);

	initial begin
		clk         = 1'b0;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		source_byte = '0;
		out_ready   = 1'b0;
		cfg_valid   = 1'b0;
		cfg_data    = '0;
		forever #5 clk = ~clk;
	end

	// token receiver
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold) begin
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				out_ready <= 1'b1;
				long_hold = 1'b0;
			end else if ($urandom_range(0, 99) < idle_pct) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 4)) @(negedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("watchdog: no request accepted for %0d cycles", WATCHDOG_LIMIT);
		$display("CHECK FAILED");
		$finish;
	end

	task automatic push_byte(input logic [7:0] b);
		@(negedge clk);
		if ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		in_valid    <= 1'b1;
		source_byte <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		bytes_sent++;
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			push_byte(s[i]);
	endtask

	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (backlog != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_limit(input logic [LEN_W-1:0] v);
		settle();
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		atom_limit = v;
	endtask

	function automatic logic [7:0] blank_char();
		case ($urandom_range(0, 5))
			0: return CH_SPACE;
			1: return CH_TAB;
			2: return CH_LF;
			3: return CH_CR;
			4: return CH_VT;
			default: return CH_FF;
		endcase
	endfunction

	function automatic logic [7:0] sign_char();
		return $urandom_range(0, 1) ? CH_PLUS : CH_MINUS;
	endfunction

	function automatic logic [7:0] atom_char();
		logic [7:0] c;
		c = 8'($urandom_range(1, 255));
		// flip bit 6 to step off a terminator
		case (c)
			CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR, CH_SPACE, CH_DQUOTE, CH_SQUOTE,
			CH_OPEN, CH_CLOSE, CH_SEMI: c = c ^ 8'h40;
			default: ;
		endcase
		return c;
	endfunction

	task automatic push_digits(input int lo, input int hi);
		repeat ($urandom_range(lo, hi))
			push_byte(CH_ZERO + 8'($urandom_range(0, 9)));
	endtask

	task automatic send_exponent();
		push_byte($urandom_range(0, 1) ? CH_LOWER_E : CH_UPPER_E);
		if ($urandom_range(0, 1)) push_byte(sign_char());
		push_digits(1, 3);
	endtask

	task automatic send_string();
		logic [7:0] c;
		push_byte(CH_DQUOTE);
		repeat ($urandom_range(0, 12)) begin
			if ($urandom_range(0, 7) == 0) begin
				push_byte(CH_BSLASH);
				push_byte(8'($urandom_range(1, 255)));
			end else begin
				c = 8'($urandom_range(1, 255));
				if (c == CH_DQUOTE || c == CH_BSLASH) c = c ^ 8'h40;
				push_byte(c);
			end
		end
		case ($urandom_range(0, 15))
			0: push_byte(CH_NUL);
			1: begin
				push_byte(CH_BSLASH);
				push_byte(CH_NUL);
			end
			default: push_byte(CH_DQUOTE);
		endcase
	endtask

	task automatic send_comment();
		logic [7:0] c;
		push_byte(CH_SEMI);
		repeat ($urandom_range(0, 10)) begin
			c = 8'($urandom_range(1, 255));
			if (c == CH_LF) c = c ^ 8'h40;
			push_byte(c);
		end
		push_byte($urandom_range(0, 9) == 0 ? CH_NUL : CH_LF);
	endtask

	task automatic send_terminator();
		case ($urandom_range(0, 11))
			0: push_byte(CH_OPEN);
			1: push_byte(CH_CLOSE);
			2: push_byte(CH_SQUOTE);
			3: send_comment();
			4: send_string();
			5: push_byte(CH_NUL);
			default: push_byte(blank_char());
		endcase
	endtask

	task automatic send_real();
		if ($urandom_range(0, 1)) push_byte(sign_char());
		case ($urandom_range(0, 3))
			0: begin
				push_byte(CH_DOT);
				push_digits(1, 4);
				if ($urandom_range(0, 1)) send_exponent();
			end
			1: begin
				push_digits(1, 4);
				push_byte(CH_DOT);
				push_digits(0, 3);
				if ($urandom_range(0, 1)) send_exponent();
			end
			2: begin
				push_digits(1, 3);
				send_exponent();
			end
			default: begin
				push_byte(CH_DOT);
				send_exponent();
			end
		endcase
	endtask

	task automatic send_broken_number();
		case ($urandom_range(0, 6))
			0: begin
				push_digits(1, 3);
				push_byte($urandom_range(0, 1) ? CH_LOWER_E : CH_UPPER_E);
			end
			1: begin
				push_digits(1, 3);
				push_byte(CH_LOWER_E);
				push_byte(sign_char());
			end
			2: push_byte(sign_char());
			3: begin
				push_byte(sign_char());
				push_byte(CH_DOT);
			end
			4: begin
				send_real();
				send_exponent();
			end
			5: begin
				push_digits(1, 4);
				push_byte(atom_char());
			end
			default: begin
				push_byte(CH_DOT);
				push_byte(CH_DOT);
			end
		endcase
	endtask

	task automatic send_token();
		int n;
		case ($urandom_range(0, 19))
			0, 1: repeat ($urandom_range(1, 3)) push_byte(blank_char());
			2: push_byte(CH_OPEN);
			3: push_byte(CH_CLOSE);
			4: push_byte(CH_SQUOTE);
			5, 6: send_string();
			7, 8: begin
				if ($urandom_range(0, 1)) push_byte(sign_char());
				push_digits(1, 6);
				send_terminator();
			end
			9, 10: begin
				send_real();
				send_terminator();
			end
			11: begin
				send_broken_number();
				send_terminator();
			end
			12, 13: begin
				repeat ($urandom_range(1, 10)) push_byte(atom_char());
				send_terminator();
			end
			14: begin
				// atoms around the length limit when it is at most 24, else short atoms
				n = (atom_limit <= 24) ? int'(atom_limit) - 1 + $urandom_range(0, 2)
					: $urandom_range(1, 24);
				if (n < 1) n = 1;
				repeat (n)
					push_byte($urandom_range(0, 1) ? atom_char()
						: CH_ZERO + 8'($urandom_range(0, 9)));
				send_terminator();
			end
			15: send_comment();
			16: push_byte(CH_NUL);
			default: repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(0, 255)));
		endcase
	endtask

	task automatic run_phase(input logic [LEN_W-1:0] limit, input int pct,
		input int count, input bit hold);
		int stop_at;
		write_limit(limit);
		idle_pct  = pct;
		long_hold = hold;
		stop_at   = bytes_sent + count;
		while (bytes_sent < stop_at)
			send_token();
	endtask

	initial begin
		bytes_sent = 0;
		idle_pct   = 20;
		long_hold  = 1'b0;
		atom_limit = MAX_ATOM_RESET;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		push_text("()'\"a\\\"\"-1.5e+7 .(42;x\n+");
		push_byte(CH_NUL);

		write_limit(LEN_W'(1));
		push_text("7)\"q");
		push_byte(CH_NUL);
		push_text("\"\\");
		push_byte(CH_NUL);
		push_text(";");
		push_byte(CH_NUL);
		push_text("\"\"");

		run_phase(LEN_W'(1), 25, 200, 1'b0);
		run_phase(LEN_W'(4095), 0, 200, 1'b0);
		run_phase(LEN_W'(6), 30, 300, 1'b1);
		run_phase(LEN_W'($urandom_range(2, 24)), 15, 300, 1'b0);
		run_phase(LEN_W'(3), 40, 300, 1'b0);
		run_phase(MAX_ATOM_RESET, 0, 250, 1'b0);
		settle();

		$display("lexed %0d source bytes into %0d checked tokens", bytes_sent, tokens_checked);
		$display("atom limits 1 to 4095, every token kind, both errors, a long output stall");
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
